// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_SYNC(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// clocked check that also holds across reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: rtl/core/crgd_pkg.sv
// Shared types and constants for the column RLE glyph decoder.
// No dependencies.
package crgd_pkg;

  localparam logic [7:0] CODE_COLEND   = 8'h80;
  localparam logic [7:0] CODE_SKIP_MAX = 8'h8F;
  localparam logic [7:0] COLOR_MASK    = 8'h0F;
  localparam logic [7:0] COLS_MAX      = 8'hFF;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REG_ORIGIN_X      = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y      = 2'd1;
  localparam logic [1:0] REG_GLYPH_COLUMNS = 2'd2;
  localparam logic [1:0] REG_MONO_MODE     = 2'd3;

  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_COLEND,
    CMD_SKIP,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    logic      start;
    cmd_kind_t kind;
    logic [3:0] amt;
    logic [3:0] color;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage

// File: rtl/core/crgd_front.sv
// Front end: accepts code items and classifies them into commands.
// Depends on crgd_pkg.
module crgd_front
  import crgd_pkg::*;
(
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] code
  input  logic       in_tuser,   // [0] start_req
  input  logic       mono,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  logic [7:0] code_col;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;
  assign code_col  = in_tdata & COLOR_MASK;

  always_comb begin
    cmd.start = in_tuser;
    cmd.color = 4'd0;
    cmd.amt   = 4'd0;
    cmd.kind  = CMD_ERR;
    priority if (in_tdata < CODE_COLEND) begin
      cmd.kind  = CMD_RUN;
      cmd.amt   = {1'b0, in_tdata[6:4]};
      cmd.color = mono ? 4'd0 : code_col[3:0];
    end else if (in_tdata == CODE_COLEND) begin
      cmd.kind = CMD_COLEND;
    end else if (in_tdata <= CODE_SKIP_MAX) begin
      cmd.kind = CMD_SKIP;
      cmd.amt  = code_col[3:0];
    end else begin
      cmd.kind = CMD_ERR;
    end
  end

endmodule

// File: rtl/core/crgd_queue.sv
// Short command queue between front and back end.
// Depends on crgd_pkg.
module crgd_queue
  import crgd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic q_valid,
  output logic q_full
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_BITS:0]   count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/core/crgd_back.sv
// Back end: walks the cursor state, emits one result per cycle unless stalled.
// Depends on crgd_pkg; holds the output register.
module crgd_back
  import crgd_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cmd_t                  cmd,
  output logic                  pop,
  input  logic [COORD_BITS-1:0] origin_x,
  input  logic [COORD_BITS-1:0] origin_y,
  input  logic [7:0]            glyph_columns,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_write,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [3:0]            out_color,
  output logic                  out_done,
  output logic                  out_err,
  output logic                  out_last
);

  bk_state_t             state_r, state_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [7:0]            cols_r, cols_nxt;
  logic                  err_r, err_nxt;
  logic [2:0]            remain_r, remain_nxt;
  logic [3:0]            color_r, color_nxt;

  logic                  out_valid_r;
  logic                  out_write_r, out_done_r, out_err_r, out_last_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [3:0]            out_color_r;

  logic                  can_emit, emit;
  logic                  e_write, e_done, e_err, e_last;
  logic [COORD_BITS-1:0] e_x, e_y;
  logic [3:0]            e_col;

  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                   input logic [3:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + (COORD_BITS+1)'(b);
    return s[COORD_BITS] ? '1 : s[COORD_BITS-1:0];
  endfunction

  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    logic [COORD_BITS-1:0] x, y;
    logic [7:0]            c;
    logic                  er;
    state_nxt  = state_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    cols_nxt   = cols_r;
    err_nxt    = err_r;
    remain_nxt = remain_r;
    color_nxt  = color_r;
    pop        = 1'b0;
    emit       = 1'b0;
    e_write    = 1'b0;
    e_x        = '0;
    e_y        = '0;
    e_col      = 4'd0;
    e_last     = 1'b1;
    e_done     = (cols_r >= glyph_columns);
    e_err      = err_r;
    x          = cmd.start ? origin_x : cur_x_r;
    y          = cmd.start ? origin_y : cur_y_r;
    c          = cmd.start ? 8'd0 : cols_r;
    er         = cmd.start ? 1'b0 : err_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && can_emit) begin
          pop  = 1'b1;
          emit = 1'b1;
          if (!er && (c < glyph_columns)) begin
            unique case (cmd.kind)
              CMD_RUN: begin
                if (cmd.amt != 4'd0) begin
                  e_write = 1'b1;
                  e_x     = x;
                  e_y     = y;
                  e_col   = cmd.color;
                  y       = sat_add(y, 4'd1);
                  if (cmd.amt != 4'd1) begin
                    e_last     = 1'b0;
                    state_nxt  = BK_RUN;
                    remain_nxt = cmd.amt[2:0] - 3'd1;
                    color_nxt  = cmd.color;
                  end
                end
              end
              CMD_COLEND: begin
                x = sat_add(x, 4'd1);
                y = origin_y;
                if (c != COLS_MAX) begin
                  c = c + 8'd1;
                end
              end
              CMD_SKIP: begin
                y = sat_add(y, cmd.amt);
              end
              CMD_ERR: begin
                er = 1'b1;
              end
              default: ;
            endcase
          end
          cur_x_nxt = x;
          cur_y_nxt = y;
          cols_nxt  = c;
          err_nxt   = er;
          e_done    = (c >= glyph_columns);
          e_err     = er;
        end
      end
      BK_RUN: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_write    = 1'b1;
          e_x        = cur_x_r;
          e_y        = cur_y_r;
          e_col      = color_r;
          cur_y_nxt  = sat_add(cur_y_r, 4'd1);
          remain_nxt = remain_r - 3'd1;
          if (remain_r == 3'd1) begin
            state_nxt = BK_IDLE;
          end else begin
            e_last = 1'b0;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cols_r      <= 8'd0;
      err_r       <= 1'b0;
      remain_r    <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      cols_r   <= cols_nxt;
      err_r    <= err_nxt;
      remain_r <= remain_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
    if (emit) begin
      out_write_r <= e_write;
      out_x_r     <= e_x;
      out_y_r     <= e_y;
      out_color_r <= e_col;
      out_done_r  <= e_done;
      out_err_r   <= e_err;
      out_last_r  <= e_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_write = out_write_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_color = out_color_r;
  assign out_done  = out_done_r;
  assign out_err   = out_err_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/core/column_rle_glyph_decoder.sv
// Column RLE glyph decoder: top level with configuration registers.
// Depends on crgd_pkg, crgd_front, crgd_queue and crgd_back.
// Each code item yields results from the back end's cursor unit, one per cycle
// unless the output stalls; a run byte of n pixels (n from 1 to 7) gives n, any
// other byte one. A two-entry command queue lets the front accept items while
// the back end emits a run; the output register holds a result while the next
// is prepared. The user does configuration writes only while idle; unenforced.
module column_rle_glyph_decoder
  import crgd_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,  // [7:0] code
  input  logic                                  in_tuser,  // [0] start_req
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // write, pixel_x, pixel_y, color, done_res, error from bit 0 up
  output logic [((2*COORD_BITS+7+7)/8)*8-1:0]   out_tdata,
  output logic                                  out_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int OUT_W = ((2*COORD_BITS+7+7)/8)*8;

  logic [COORD_BITS-1:0] origin_x_r, origin_y_r;
  logic [7:0]            gcols_r;
  logic                  mono_r;

  logic                  cfg_wr;
  logic                  push, pop, q_valid, q_full;
  cmd_t                  cmd_in, cmd_out;
  logic                  o_write, o_done, o_err;
  logic [COORD_BITS-1:0] o_x, o_y;
  logic [3:0]            o_color;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      gcols_r    <= 8'd0;
      mono_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ORIGIN_X:      origin_x_r <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y:      origin_y_r <= pwdata[COORD_BITS-1:0];
        REG_GLYPH_COLUMNS: gcols_r    <= pwdata[7:0];
        REG_MONO_MODE:     mono_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ORIGIN_X:      prdata = 32'(origin_x_r);
      REG_ORIGIN_Y:      prdata = 32'(origin_y_r);
      REG_GLYPH_COLUMNS: prdata = 32'(gcols_r);
      REG_MONO_MODE:     prdata = 32'(mono_r);
      default:           prdata = 32'd0;
    endcase
  end

  crgd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .mono      (mono_r),
    .q_full    (q_full),
    .push      (push),
    .cmd       (cmd_in)
  );

  crgd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .din     (cmd_in),
    .pop     (pop),
    .dout    (cmd_out),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  crgd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .cmd           (cmd_out),
    .pop           (pop),
    .origin_x      (origin_x_r),
    .origin_y      (origin_y_r),
    .glyph_columns (gcols_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_write     (o_write),
    .out_x         (o_x),
    .out_y         (o_y),
    .out_color     (o_color),
    .out_done      (o_done),
    .out_err       (o_err),
    .out_last      (out_tlast)
  );

  assign out_tdata = OUT_W'({o_err, o_done, o_color, o_y, o_x, o_write});

endmodule

// File: rtl/core/crgd_checker.sv
// Port-level checks for the column RLE glyph decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module crgd_checker #(
  parameter int COORD_BITS = 10
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((2*COORD_BITS+7+7)/8)*8-1:0] out_tdata,
  input logic                                out_tlast
);

  localparam int DONE_BIT = 2*COORD_BITS + 5;
  localparam int ERR_BIT  = 2*COORD_BITS + 6;

  `ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid)
  `ASSERT_SYNC(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `ASSERT_SYNC(a_nowrite_zero, clk, rst_n, out_tvalid && !out_tdata[0] |-> out_tdata[2*COORD_BITS+4:1] == '0)
  `ASSERT_SYNC(a_write_live, clk, rst_n, out_tvalid && out_tdata[0] |-> !out_tdata[DONE_BIT] && !out_tdata[ERR_BIT])

endmodule

bind column_rle_glyph_decoder crgd_checker #(
  .COORD_BITS (COORD_BITS)
) u_crgd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
